// ----- rtl/h264fu_pkg.sv -----
package h264fu_pkg;

  localparam int unsigned SizeW = 16;
  localparam int unsigned LimitW = 11;
  localparam logic [LimitW-1:0] PayloadFloor = 11'd1024;
  localparam logic [31:0] RtpClockPerMs = 32'd90;

  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_DROP_BFRAMES = 1'b1;

  typedef struct packed {
    logic [SizeW-1:0] left;
    logic [7:0]       hdr;
    logic [31:0]      rtp_ts;
    logic             fend;
    logic             frag;
  } unit_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_t;

endpackage

// ----- rtl/h264_nalu_rtp_fragmenter.sv -----
// H.264 RTP packetizer, single NAL unit and FU-A modes. Each input transaction describes one
// NAL unit; each output transaction describes one RTP packet with its sequence number,
// 90 kHz timestamp, payload offset and length. A unit no larger than max_payload (floored at
// 1024) gives one packet; a larger one is split into FU-A fragments that skip the header byte.
// Units flagged as B-frames are discarded while drop_bframes is set, as are empty units.
// Timing: the fragment walker emits one packet per cycle while the output is not stalled,
// and loads each unit from a two-entry queue between units; the front takes a new unit every
// cycle while the queue has room. Write configuration only while the block is idle.
module h264_nalu_rtp_fragmenter import h264fu_pkg::*; #(
  parameter int unsigned MAX_NALU_BYTES = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [LimitW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       nalu_size,
  input  logic [7:0]        nalu_header,
  input  logic [31:0]       timestamp_ms,
  input  logic              is_bframe,
  input  logic              frame_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       seq_number,
  output logic [31:0]       rtp_timestamp,
  output logic              is_fragment,
  output logic [7:0]        nri_header,
  output logic [4:0]        nal_kind,
  output logic              frag_start,
  output logic              frag_end,
  output logic [15:0]       payload_offset,
  output logic [15:0]       payload_length,
  output logic              marker,
  output logic              run_last
);

  logic [LimitW-1:0] max_payload;
  logic              drop_bframes;
  logic [LimitW-1:0] limit;

  logic  push;
  unit_t push_unit;
  logic  q_ready;
  logic  q_valid;
  unit_t q_unit;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= 11'd1300;
      drop_bframes <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_PAYLOAD:  max_payload <= cfg_data;
        REG_DROP_BFRAMES: drop_bframes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign limit = (max_payload < PayloadFloor) ? PayloadFloor : max_payload;

  h264fu_front #(
    .MAX_NALU_BYTES(MAX_NALU_BYTES)
  ) u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .nalu_size    (nalu_size),
    .nalu_header  (nalu_header),
    .timestamp_ms (timestamp_ms),
    .is_bframe    (is_bframe),
    .frame_end    (frame_end),
    .limit        (limit),
    .drop_bframes (drop_bframes),
    .push         (push),
    .push_unit    (push_unit),
    .q_ready      (q_ready)
  );

  h264fu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_unit (push_unit),
    .q_ready   (q_ready),
    .q_valid   (q_valid),
    .q_unit    (q_unit),
    .pop       (pop)
  );

  h264fu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .limit          (limit),
    .q_valid        (q_valid),
    .q_unit         (q_unit),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .seq_number     (seq_number),
    .rtp_timestamp  (rtp_timestamp),
    .is_fragment    (is_fragment),
    .nri_header     (nri_header),
    .nal_kind       (nal_kind),
    .frag_start     (frag_start),
    .frag_end       (frag_end),
    .payload_offset (payload_offset),
    .payload_length (payload_length),
    .marker         (marker),
    .run_last       (run_last)
  );

endmodule

// ----- rtl/h264fu_front.sv -----
module h264fu_front import h264fu_pkg::*; #(
  parameter int unsigned MAX_NALU_BYTES = 65535
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       nalu_size,
  input  logic [7:0]        nalu_header,
  input  logic [31:0]       timestamp_ms,
  input  logic              is_bframe,
  input  logic              frame_end,
  input  logic [LimitW-1:0] limit,
  input  logic              drop_bframes,
  output logic              push,
  output unit_t             push_unit,
  input  logic              q_ready
);

  localparam logic [SizeW-1:0] MaxBytes = SizeW'(MAX_NALU_BYTES);

  logic [SizeW-1:0] size_sat;
  logic             keep;
  logic             frag;

  always_comb begin
    size_sat = (nalu_size > MaxBytes) ? MaxBytes : nalu_size;
    keep = !(drop_bframes && is_bframe) && (size_sat != '0);
    frag = size_sat > {{(SizeW-LimitW){1'b0}}, limit};
  end

  assign in_ready = q_ready;
  assign push = in_valid && q_ready && keep;

  always_comb begin
    push_unit.left = frag ? (size_sat - SizeW'(1)) : size_sat;
    push_unit.hdr = nalu_header;
    push_unit.rtp_ts = timestamp_ms * RtpClockPerMs;
    push_unit.fend = frame_end;
    push_unit.frag = frag;
  end

endmodule

// ----- rtl/h264fu_queue.sv -----
module h264fu_queue import h264fu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  unit_t push_unit,
  output logic  q_ready,
  output logic  q_valid,
  output unit_t q_unit,
  input  logic  pop
);

  unit_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_unit = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/h264fu_back.sv -----
module h264fu_back import h264fu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [LimitW-1:0] limit,
  input  logic              q_valid,
  input  unit_t             q_unit,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       seq_number,
  output logic [31:0]       rtp_timestamp,
  output logic              is_fragment,
  output logic [7:0]        nri_header,
  output logic [4:0]        nal_kind,
  output logic              frag_start,
  output logic              frag_end,
  output logic [15:0]       payload_offset,
  output logic [15:0]       payload_length,
  output logic              marker,
  output logic              run_last
);

  back_state_t      state;
  back_state_t      state_next;
  unit_t            cur;
  logic [SizeW-1:0] off;
  logic             first;
  logic [15:0]      seq_counter;

  logic [SizeW-1:0] limit_w;
  logic             last;
  logic [SizeW-1:0] len;
  logic             can_emit;
  logic             emit;

  always_comb begin
    limit_w = {{(SizeW-LimitW){1'b0}}, limit};
    last = !cur.frag || (cur.left <= limit_w);
    len = last ? cur.left : limit_w;
    can_emit = !out_valid || out_ready;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BACK_IDLE: begin
        if (q_valid) begin
          state_next = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (can_emit && last) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == BACK_IDLE) && q_valid;
    emit = (state == BACK_RUN) && can_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BACK_IDLE;
      seq_counter <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        seq_counter <= seq_counter + 16'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working unit, walks one packet per emit
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_unit;
      off <= q_unit.frag ? SizeW'(1) : '0;
      first <= 1'b1;
    end else if (emit) begin
      cur.left <= cur.left - len;
      off <= off + len;
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      seq_number <= seq_counter;
      rtp_timestamp <= cur.rtp_ts;
      is_fragment <= cur.frag;
      nri_header <= cur.hdr;
      nal_kind <= cur.frag ? cur.hdr[4:0] : 5'd0;
      frag_start <= cur.frag && first;
      frag_end <= cur.frag && last;
      payload_offset <= off;
      payload_length <= len;
      marker <= last && cur.fend;
      run_last <= last;
    end
  end

endmodule

// ----- verif/h264_nalu_rtp_fragmenter_tb.sv -----
module h264_nalu_rtp_fragmenter_tb;
  import h264fu_pkg::*;

  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] ts;
    logic        frag;
    logic [7:0]  hdr;
    logic [4:0]  kind;
    logic        first;
    logic        final_frag;
    logic [15:0] off;
    logic [15:0] len;
    logic        mark;
    logic        run_end;
  } rtp_pkt_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [LimitW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [15:0]       nalu_size = '0;
  logic [7:0]        nalu_header = '0;
  logic [31:0]       timestamp_ms = '0;
  logic              is_bframe = 1'b0;
  logic              frame_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       seq_number;
  logic [31:0]       rtp_timestamp;
  logic              is_fragment;
  logic [7:0]        nri_header;
  logic [4:0]        nal_kind;
  logic              frag_start;
  logic              frag_end;
  logic [15:0]       payload_offset;
  logic [15:0]       payload_length;
  logic              marker;
  logic              run_last;

  // shadow of the block's configuration and sequence counter
  logic [LimitW-1:0] pay_limit = 11'd1300;
  logic              drop_b = 1'b0;
  logic [15:0]       next_seq = '0;

  rtp_pkt_t rtp_packets_due[$];
  rtp_pkt_t head_pkt;
  int       errors = 0;
  int       cycle_count = 0;
  logic     tx_idle = 1'b1;
  logic     rx_idle = 1'b1;
  int       hold_len = 0;

  h264_nalu_rtp_fragmenter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .nalu_size(nalu_size),
    .nalu_header(nalu_header),
    .timestamp_ms(timestamp_ms),
    .is_bframe(is_bframe),
    .frame_end(frame_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .seq_number(seq_number),
    .rtp_timestamp(rtp_timestamp),
    .is_fragment(is_fragment),
    .nri_header(nri_header),
    .nal_kind(nal_kind),
    .frag_start(frag_start),
    .frag_end(frag_end),
    .payload_offset(payload_offset),
    .payload_length(payload_length),
    .marker(marker),
    .run_last(run_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d packets outstanding", $time, rtp_packets_due.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [15:0] effective_limit();
    return (pay_limit < PayloadFloor) ? 16'(PayloadFloor) : 16'(pay_limit);
  endfunction

  function automatic void queue_packet(input rtp_pkt_t p);
    p.seq = next_seq;
    next_seq = next_seq + 16'd1;
    rtp_packets_due.insert(rtp_packets_due.size(), p);
  endfunction

  // packet descriptors that one NAL unit should turn into
  function automatic void packetize_unit(input logic [15:0] size, input logic [7:0] hdr,
                                         input logic [31:0] ts_ms, input logic bf,
                                         input logic fe);
    logic [15:0] lim;
    logic [15:0] left;
    logic [15:0] off;
    logic [15:0] len;
    rtp_pkt_t    p;
    lim = effective_limit();
    if (drop_b && bf) return;
    if (size == 16'd0) return;
    p = '0;
    p.ts = ts_ms * RtpClockPerMs;
    p.hdr = hdr;
    if (size <= lim) begin
      p.len = size;
      p.mark = fe;
      p.run_end = 1'b1;
      queue_packet(p);
    end else begin
      left = size - 16'd1;
      off = 16'd1;
      while (left != 16'd0) begin
        len = (left < lim) ? left : lim;
        p.frag = 1'b1;
        p.kind = hdr[4:0];
        p.first = (off == 16'd1);
        p.final_frag = (len == left);
        p.off = off;
        p.len = len;
        p.mark = (len == left) ? fe : 1'b0;
        p.run_end = (len == left);
        queue_packet(p);
        off = off + len;
        left = left - len;
      end
    end
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (rtp_packets_due.size() == 0) begin
        $display("%0t: unexpected packet, seq %0h", $time, seq_number);
        errors++;
      end else begin
        head_pkt = rtp_packets_due.pop_front();
        check_field("seq_number", 32'(head_pkt.seq), 32'(seq_number));
        check_field("rtp_timestamp", head_pkt.ts, rtp_timestamp);
        check_field("is_fragment", 32'(head_pkt.frag), 32'(is_fragment));
        check_field("nri_header", 32'(head_pkt.hdr), 32'(nri_header));
        check_field("nal_kind", 32'(head_pkt.kind), 32'(nal_kind));
        check_field("frag_start", 32'(head_pkt.first), 32'(frag_start));
        check_field("frag_end", 32'(head_pkt.final_frag), 32'(frag_end));
        check_field("payload_offset", 32'(head_pkt.off), 32'(payload_offset));
        check_field("payload_length", 32'(head_pkt.len), 32'(payload_length));
        check_field("marker", 32'(head_pkt.mark), 32'(marker));
        check_field("run_last", 32'(head_pkt.run_end), 32'(run_last));
      end
    end
  end

  // packet sink with random stalls and an occasional long hold-off
  initial begin : packet_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_unit(input logic [15:0] size, input logic [7:0] hdr,
                           input logic [31:0] ts_ms, input logic bf, input logic fe);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    nalu_size <= size;
    nalu_header <= hdr;
    timestamp_ms <= ts_ms;
    is_bframe <= bf;
    frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    packetize_unit(size, hdr, ts_ms, bf, fe);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (rtp_packets_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LimitW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_PAYLOAD) pay_limit = val;
    else drop_b = val[0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_size();
    logic [15:0] lim;
    lim = effective_limit();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1, 2, 3: return 16'($urandom_range(1, lim));
      4: return lim + 16'($urandom_range(0, 2));
      5: return 16'(2 * lim) + 16'($urandom_range(0, 2));
      default: return 16'($urandom_range(1, 6000));
    endcase
  endfunction

  task automatic send_random_unit();
    send_unit(pick_size(), 8'($urandom_range(0, 255)), $urandom,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // single packets, fragment boundaries, empty and largest units at the reset limit
  task automatic test_unit_edges();
    send_unit(16'd1, 8'h00, 32'h0000_0000, 1'b0, 1'b1);
    send_unit(16'd1300, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_unit(16'd1301, 8'h65, 32'h0000_0001, 1'b0, 1'b1);
    send_unit(16'd1302, 8'h41, 32'h02FA_F080, 1'b0, 1'b0);
    send_unit(16'd2601, 8'h9A, 32'h7FFF_FFFF, 1'b0, 1'b1);
    send_unit(16'd0, 8'h67, 32'h1234_5678, 1'b0, 1'b1);
    send_unit(16'd65535, 8'h5C, 32'h8000_0000, 1'b0, 1'b1);
    send_unit(16'd500, 8'h21, 32'h0000_0BB8, 1'b1, 1'b0);
    settle();
  endtask

  task automatic test_bframe_drop();
    write_reg(REG_DROP_BFRAMES, 11'd1);
    send_unit(16'd3000, 8'h01, 32'h0000_1000, 1'b1, 1'b1);
    send_unit(16'd0, 8'h01, 32'h0000_1001, 1'b1, 1'b0);
    send_unit(16'd3000, 8'h65, 32'h0000_1002, 1'b0, 1'b1);
    send_unit(16'd100, 8'h01, 32'h0000_1003, 1'b1, 1'b1);
    settle();
    write_reg(REG_DROP_BFRAMES, 11'd0);
  endtask

  task automatic test_payload_limits();
    write_reg(REG_MAX_PAYLOAD, 11'd1024);
    send_unit(16'd65535, 8'h7C, 32'hDEAD_BEEF, 1'b0, 1'b1);
    send_unit(16'd1025, 8'h3C, 32'h0000_0010, 1'b0, 1'b1);
    send_unit(16'd1024, 8'hE5, 32'h0000_0011, 1'b0, 1'b0);
    settle();
    write_reg(REG_MAX_PAYLOAD, 11'd1500);
    send_unit(16'd1501, 8'h45, 32'h0000_0020, 1'b0, 1'b1);
    send_unit(16'd65535, 8'hA1, 32'h0000_0021, 1'b0, 1'b0);
    settle();
    write_reg(REG_MAX_PAYLOAD, 11'd2047);
    send_unit(16'd2047, 8'h06, 32'h0000_0030, 1'b0, 1'b1);
    send_unit(16'd2049, 8'h1F, 32'h0000_0031, 1'b0, 1'b1);
    settle();
    // limits under the floor act as 1024
    write_reg(REG_MAX_PAYLOAD, 11'd0);
    send_unit(16'd1025, 8'h41, 32'h0000_0040, 1'b0, 1'b1);
    send_unit(16'd1024, 8'h41, 32'h0000_0041, 1'b0, 1'b1);
    settle();
    write_reg(REG_MAX_PAYLOAD, 11'd1023);
    send_unit(16'd1024, 8'h61, 32'h0000_0050, 1'b0, 1'b0);
    send_unit(16'd1025, 8'h61, 32'h0000_0051, 1'b0, 1'b1);
    settle();
  endtask

  // sink holds off long enough for the input side to back up
  task automatic test_backpressure();
    write_reg(REG_MAX_PAYLOAD, 11'd1024);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_len = 500;
    repeat (16) send_unit(16'($urandom_range(1, 5000)), 8'($urandom_range(0, 255)),
                          $urandom, 1'b0, 1'($urandom_range(0, 1)));
    settle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    logic [LimitW-1:0] lim;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: lim = 11'd1500;
        2: lim = 11'($urandom_range(0, 2047));
        3: lim = 11'd1024;
        default: lim = 11'($urandom_range(1024, 1500));
      endcase
      write_reg(REG_MAX_PAYLOAD, lim);
      write_reg(REG_DROP_BFRAMES, 11'(phase % 2));
      tx_idle = (phase != 2);
      rx_idle = (phase != 2) && (phase != 4);
      repeat (66) send_random_unit();
      settle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_unit_edges();
    test_bframe_drop();
    test_payload_limits();
    test_backpressure();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (errors == 0 && rtp_packets_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/h264fu_pkg.sv
rtl/h264fu_front.sv
rtl/h264fu_queue.sv
rtl/h264fu_back.sv
rtl/h264_nalu_rtp_fragmenter.sv
verif/h264_nalu_rtp_fragmenter_tb.sv
